>>> rtl/wdraw_pkg.sv
// ----------------------------------------------------------------------------
// wdraw_pkg: shared types and codes of the weighted draw unit
// Request codes, status codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package wdraw_pkg;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_DRAW  = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NONE   = 3'd1;
    localparam logic [2:0] ST_GROUP  = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_WEIGHT = 3'd4;
    localparam logic [2:0] ST_RANGE  = 3'd5;
    localparam logic [2:0] ST_FULL   = 3'd6;

    localparam int NUM_WEIGHTS = 8;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_FILL   = 11'b00000000010,
        S_SUM    = 11'b00000000100,
        S_CHECK  = 11'b00000001000,
        S_MOD1   = 11'b00000010000,
        S_PICK   = 11'b00000100000,
        S_MOD2   = 11'b00001000000,
        S_RDLAST = 11'b00010000000,
        S_RDPOS  = 11'b00100000000,
        S_SWAP   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

endpackage

>>> rtl/wdraw_ram.sv
// ----------------------------------------------------------------------------
// wdraw_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module wdraw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/wdraw_mod.sv
// ----------------------------------------------------------------------------
// wdraw_mod: iterative 32-bit unsigned modulo
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wdraw_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);
    logic [31:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;

    assign shifted   = {rem_reg[31:0], num_reg[31]};
    assign done      = done_reg;
    assign remainder = rem_reg[31:0];

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[30:0], 1'b0};
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
            end
            else
            begin
                rem_next = shifted;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end
endmodule

>>> rtl/weighted_draw_without_replacement_unit.sv
// Clear, unknown and rejected requests go straight to the result; an add checks
// room, then writes its range unless it does not fit; a draw sums the weighted
// counts, runs the shared bit-serial modulo unit twice unless it fails its ticket
// or weight check. Throughput: one request at a time; in_stall stays high until
// the result is taken. Reset clears all counts, highest group and sets weights to
// 1; pool memory contents stay undefined and are only read below a count.
// ----------------------------------------------------------------------------
// weighted_draw_without_replacement_unit: weighted ticket draw
// Per-group ticket pools in one RAM, a shared modulo unit, and a sequencer.
// ----------------------------------------------------------------------------
module weighted_draw_without_replacement_unit #(
    parameter int GROUPS     = 8,
    parameter int POOL_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [3:0]  group,
    input  logic [15:0] first_number,
    input  logic [15:0] last_number,
    input  logic [7:0]  group_mask,
    input  logic [31:0] random_group,
    input  logic [31:0] random_ticket,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] winning_number,
    output logic [3:0]  winning_group,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wdraw_pkg::*;

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(GROUPS * POOL_DEPTH);

    state_t state_reg, state_next;

    // weight registers and config reads
    logic [7:0] weight_reg [NUM_WEIGHTS];
    assign pready = 1'b1;
    always_comb
    begin
        prdata = {24'd0, weight_reg[paddr[4:2]]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WEIGHTS; i++)
            begin
                weight_reg[i] <= 8'd1;
            end
        end
        else if (psel && penable && pwrite)
        begin
            weight_reg[paddr[4:2]] <= pwdata[7:0];
        end
    end

    // pool counts and highest group
    logic [CW-1:0] count_reg [GROUPS];
    logic [3:0]    high_reg;

    // latched request
    logic [1:0]  req_reg;
    logic [3:0]  grp_reg;
    logic [15:0] first_reg, last_reg;
    logic [7:0]  mask_reg;
    logic [31:0] rg_reg, rt_reg;

    // working registers
    logic [GW-1:0] gidx_reg;
    logic          tick_nz_reg;
    logic [31:0]   total_reg;
    logic [31:0]   acc_reg;
    logic [31:0]   pick_reg;
    logic [GW-1:0] sel_reg;
    logic [15:0]   fill_reg;         // next number to write
    logic [CW-1:0] wr_reg;           // next write slot
    logic [PW-1:0] pos_reg;
    logic [15:0]   lastval_reg;
    logic [15:0]   win_reg;
    logic [2:0]    st_reg;
    logic [3:0]    wgrp_reg;

    // shared modulo unit
    logic        mod_start, mod_done;
    logic [31:0] mod_a, mod_b, mod_r;
    wdraw_mod u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(mod_a),
        .divisor(mod_b), .done(mod_done), .remainder(mod_r)
    );

    // pool memory
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata, ram_rdata;
    wdraw_ram #(.WIDTH(16), .DEPTH(GROUPS * POOL_DEPTH)) u_pool (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    function automatic logic [AW-1:0] pool_addr(input logic [GW-1:0] g,
                                                 input logic [PW-1:0] p);
        logic [AW+GW:0] a;
        a = (AW+GW+1)'(g) * (AW+GW+1)'(POOL_DEPTH) + (AW+GW+1)'(p);
        return a[AW-1:0];
    endfunction

    logic accept;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign status         = st_reg;
    assign winning_number = win_reg;
    assign winning_group  = wgrp_reg;

    // current group: weighted count (9 x 8 bits, one small multiply)
    logic [CW-1:0] cur_cnt;
    logic [31:0]   cur_w;
    logic          cur_in;
    logic          last_g;
    logic [GW-1:0] add_idx;
    logic [16:0]   add_len;
    logic [CW:0]   add_room;
    logic          add_full;
    logic          grp_bad;
    assign cur_cnt = count_reg[gidx_reg];
    assign cur_w   = 32'(cur_cnt) * 32'(weight_reg[3'(gidx_reg)]);
    assign cur_in  = mask_reg[gidx_reg] && (4'(gidx_reg) < high_reg);
    assign last_g  = (gidx_reg == GW'(GROUPS - 1));
    assign add_idx = GW'(grp_reg - 4'd1);
    assign add_room = (CW+1)'(POOL_DEPTH) - (CW+1)'(count_reg[add_idx]);
    assign add_full = (add_len > 17'(add_room));

    always_comb
    begin
        grp_bad = 1'b0;
        for (int g = 0; g < 8; g++)
        begin
            if (group_mask[g] && (4'(g + 1) > high_reg))
            begin
                grp_bad = 1'b1;
            end
        end
    end

    logic [16:0] range_len;
    assign range_len = {1'b0, last_number} - {1'b0, first_number} + 17'd1;

    assign mod_start = (state_reg == S_CHECK && tick_nz_reg && total_reg != 0)
                    || (state_reg == S_PICK && (cur_in && pick_reg < acc_reg + cur_w));
    assign mod_a = (state_reg == S_CHECK) ? rg_reg : rt_reg;
    assign mod_b = (state_reg == S_CHECK) ? total_reg : 32'(cur_cnt);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = pool_addr(add_idx, wr_reg[PW-1:0]);
        ram_wdata = fill_reg;
        case (state_reg)
            S_FILL:
            begin
                ram_we = 1'b1;
            end
            S_MOD2:
            begin
                ram_addr = pool_addr(sel_reg, PW'(count_reg[sel_reg] - CW'(1)));
            end
            S_RDLAST:
            begin
                ram_addr = pool_addr(sel_reg, pos_reg);
            end
            S_SWAP:
            begin
                ram_we    = 1'b1;
                ram_addr  = pool_addr(sel_reg, pos_reg);
                ram_wdata = lastval_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            high_reg  <= '0;
            for (int g = 0; g < GROUPS; g++)
            begin
                count_reg[g] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // clear request
            if (accept && req_type == REQ_CLEAR)
            begin
                high_reg <= '0;
                for (int g = 0; g < GROUPS; g++)
                begin
                    count_reg[g] <= '0;
                end
            end
            // advance count at end of fill
            if (state_reg == S_FILL && fill_reg == last_reg)
            begin
                count_reg[add_idx] <= wr_reg + CW'(1);
                if (grp_reg > high_reg)
                begin
                    high_reg <= grp_reg;
                end
            end
            if (state_reg == S_SWAP)
            begin
                count_reg[sel_reg] <= count_reg[sel_reg] - CW'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_OUT;
                    if (req_type == REQ_ADD && group >= 4'd1 &&
                        group <= 4'(GROUPS) && last_number >= first_number)
                    begin
                        state_next = S_CHECK; // room check next cycle
                    end
                    else if (req_type == REQ_DRAW && high_reg != 0 && !grp_bad)
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:    if (last_g) state_next = S_CHECK;
            S_CHECK:
            begin
                if (req_reg == REQ_ADD)
                begin
                    state_next = add_full ? S_OUT : S_FILL;
                end
                else
                begin
                    state_next = mod_start ? S_MOD1 : S_OUT;
                end
            end
            S_FILL:   if (fill_reg == last_reg) state_next = S_OUT;
            S_MOD1:   if (mod_done) state_next = S_PICK;
            S_PICK:   if (mod_start) state_next = S_MOD2;
            S_MOD2:   if (mod_done) state_next = S_RDLAST;
            S_RDLAST: state_next = S_RDPOS;
            S_RDPOS:  state_next = S_SWAP;
            S_SWAP:   state_next = S_OUT;
            S_OUT:    if (!out_stall) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign add_len = {1'b0, last_reg} - {1'b0, first_reg} + 17'd1;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_reg   <= req_type;
                    grp_reg   <= group;
                    first_reg <= first_number;
                    last_reg  <= last_number;
                    mask_reg  <= group_mask;
                    rg_reg    <= random_group;
                    rt_reg    <= random_ticket;
                    fill_reg  <= first_number;
                    gidx_reg  <= '0;
                    tick_nz_reg <= 1'b0;
                    total_reg <= '0;
                    acc_reg   <= '0;
                    win_reg   <= '0;
                    wgrp_reg  <= '0;
                    st_reg    <= ST_OK;
                    if (req_type == REQ_ADD)
                    begin
                        if (group < 4'd1 || group > 4'(GROUPS))
                            st_reg <= ST_GROUP;
                        else if (last_number < first_number)
                            st_reg <= ST_RANGE;
                        else if (range_len > 17'(POOL_DEPTH))
                            st_reg <= ST_FULL;
                    end
                    else if (req_type == REQ_DRAW)
                    begin
                        if (high_reg == 0)
                            st_reg <= ST_NONE;
                        else if (grp_bad)
                            st_reg <= ST_GROUP;
                    end
                end
            end
            S_SUM:
            begin
                if (cur_in)
                begin
                    total_reg <= total_reg + cur_w;
                    if (cur_cnt != 0)
                        tick_nz_reg <= 1'b1;
                end
                gidx_reg <= last_g ? '0 : gidx_reg + GW'(1);
            end
            S_CHECK:
            begin
                if (req_reg == REQ_ADD)
                begin
                    wr_reg <= count_reg[add_idx];
                    if (add_full)
                        st_reg <= ST_FULL;
                end
                else if (!tick_nz_reg)
                    st_reg <= ST_EMPTY;
                else if (total_reg == 0)
                    st_reg <= ST_WEIGHT;
            end
            S_FILL:
            begin
                fill_reg <= fill_reg + 16'd1;
                if (fill_reg != last_reg)
                    wr_reg <= wr_reg + CW'(1);
            end
            S_MOD1:
            begin
                if (mod_done)
                    pick_reg <= mod_r;
            end
            S_PICK:
            begin
                if (cur_in)
                    acc_reg <= acc_reg + cur_w;
                if (mod_start)
                    sel_reg <= gidx_reg;
                else
                    gidx_reg <= gidx_reg + GW'(1);
            end
            S_MOD2:
            begin
                if (mod_done)
                    pos_reg <= mod_r[PW-1:0];
            end
            S_RDLAST:
            begin
                lastval_reg <= ram_rdata;
            end
            S_RDPOS:
            begin
                win_reg  <= ram_rdata;
                wgrp_reg <= 4'(sel_reg) + 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    logic unused_ok;
    assign unused_ok = ^{paddr[1:0], pwdata[31:8], psel};
endmodule
